// File: design/assert_macros.svh
// Assertion macros used by the top level of the rotate-translate block.
// Depends on nothing; each macro samples on the clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// File: design/rtv_pkg.sv
// Package of the rotate-translate block: payload structs, register indexes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rtv_pkg;

   localparam int ROWS       = 3;
   localparam int COEF_W     = 16;
   localparam int VEC_W      = 16;
   localparam int TRANS_W    = 32;
   localparam int ROW_W      = ROWS * COEF_W;
   localparam int FRAC_W     = 12;
   localparam int ACC_W      = 44;
   localparam int MAC_W      = 32;
   localparam int IR_W       = 16;
   localparam int FLAGS_W    = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic signed [IR_W-1:0] IR_MAX = 16'sh7FFF;
   localparam logic signed [IR_W-1:0] IR_MIN = 16'sh8000;

   // Flag layout: positive overflow at 30-r, negative at 27-r, saturation at 24-r.
   localparam int FLAG_POS_TOP   = 30;
   localparam int FLAG_NEG_TOP   = 27;
   localparam int FLAG_SAT_TOP   = 24;
   localparam int FLAG_SUMMARY   = 31;
   localparam logic [FLAGS_W-1:0] FLAG_SUMMARY_MASK = 32'h7F87_E000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_ROW0 = 3'd0,
      CSR_ROT_ROW1 = 3'd1,
      CSR_ROT_ROW2 = 3'd2,
      CSR_TRANS_X  = 3'd3,
      CSR_TRANS_Y  = 3'd4,
      CSR_TRANS_Z  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] vec_x;
      logic signed [VEC_W-1:0] vec_y;
      logic signed [VEC_W-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [MAC_W-1:0] mac_x;
      logic signed [MAC_W-1:0] mac_y;
      logic signed [MAC_W-1:0] mac_z;
      logic signed [IR_W-1:0]  ir_x;
      logic signed [IR_W-1:0]  ir_y;
      logic signed [IR_W-1:0]  ir_z;
      logic [FLAGS_W-1:0]      flags;
   } rsp_type;

   typedef struct packed {
      logic [ROWS-1:0][ROW_W-1:0]   rot;
      logic [ROWS-1:0][TRANS_W-1:0] trans;
   } cfg_type;

   typedef struct packed {
      logic pos_ovf;
      logic neg_ovf;
      logic sat;
   } row_flags_type;

endpackage

// File: design/rtv_csr.sv
// Configuration registers of the rotate-translate block: matrix rows and translation.
// Depends on rtv_pkg.
`timescale 1ns / 1ps

module rtv_csr
   import rtv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_ROW0: cfg_ff.rot[0]   <= csr_wdata;
            CSR_ROT_ROW1: cfg_ff.rot[1]   <= csr_wdata;
            CSR_ROT_ROW2: cfg_ff.rot[2]   <= csr_wdata;
            CSR_TRANS_X:  cfg_ff.trans[0] <= csr_wdata[TRANS_W-1:0];
            CSR_TRANS_Y:  cfg_ff.trans[1] <= csr_wdata[TRANS_W-1:0];
            CSR_TRANS_Z:  cfg_ff.trans[2] <= csr_wdata[TRANS_W-1:0];
            default: ;  // Unknown indexes are dropped.
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/rtv_row.sv
// One output row: translation plus three coefficient products, 44-bit wrap, flags, clamp.
// Depends on rtv_pkg.
`timescale 1ns / 1ps

module rtv_row
   import rtv_pkg::*;
(
   input  logic [ROW_W-1:0]          rot_row,
   input  logic [TRANS_W-1:0]        trans,
   input  req_type                   vec,
   output logic signed [MAC_W-1:0]   mac,
   output logic signed [IR_W-1:0]    ir,
   output row_flags_type             row_flags
);

   logic signed [VEC_W-1:0]  vin [ROWS];
   logic signed [COEF_W-1:0] coef [ROWS];
   logic signed [2*VEC_W-1:0] prod [ROWS];
   logic [ACC_W-1:0]          acc;
   logic [ACC_W:0]            sum;
   logic                      pos_ovf;
   logic                      neg_ovf;
   logic                      sat;

   assign vin[0] = vec.vec_x;
   assign vin[1] = vec.vec_y;
   assign vin[2] = vec.vec_z;

   // The three products are independent; only the additions chain.
   always_comb begin
      for (int c = 0; c < ROWS; c++) begin
         coef[c] = rot_row[COEF_W*c +: COEF_W];
         prod[c] = coef[c] * vin[c];
      end
   end

   // The scaled translation already fits 44 bits, so the chain starts unwrapped.
   // Each add is checked on its 45-bit result: the top two bits disagree on overflow.
   always_comb begin
      acc     = {trans, {FRAC_W{1'b0}}};
      sum     = '0;
      pos_ovf = 1'b0;
      neg_ovf = 1'b0;
      for (int c = 0; c < ROWS; c++) begin
         sum     = {acc[ACC_W-1], acc}
                 + {{(ACC_W + 1 - 2*VEC_W){prod[c][2*VEC_W-1]}}, prod[c]};
         pos_ovf = pos_ovf | (~sum[ACC_W] & sum[ACC_W-1]);
         neg_ovf = neg_ovf | (sum[ACC_W] & ~sum[ACC_W-1]);
         acc     = sum[ACC_W-1:0];
      end
   end

   assign mac = acc[ACC_W-1:FRAC_W];

   // The value fits 16 bits only when bits 31 down to 15 all agree.
   assign sat = (mac[MAC_W-1:IR_W-1] != {(MAC_W-IR_W+1){mac[MAC_W-1]}});

   always_comb begin
      if (!sat) begin
         ir = mac[IR_W-1:0];
      end else if (mac[MAC_W-1]) begin
         ir = IR_MIN;
      end else begin
         ir = IR_MAX;
      end
   end

   assign row_flags = '{pos_ovf: pos_ovf, neg_ovf: neg_ovf, sat: sat};

endmodule

// File: design/rotate_translate_vector_with_flags_core.sv
// Top level of the rotate-translate block: handshake, input and result registers.
// Depends on rtv_pkg, rtv_csr, rtv_row and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// The block multiplies a signed 16-bit 3-vector by a 1.3.12 rotation matrix and
// adds a translation scaled by 4096, one row per output coordinate. Each row
// reports 44-bit overflow in both directions and saturation of its 16-bit IR value
// in a flag word, whose bit 31 summarizes the error bits of the mask 0x7F87E000.
// Input transactions arrive on req_valid / req_stall / req_data, results leave on
// rsp_valid / rsp_stall / rsp_data. A transaction moves when valid is high and
// stall is low. The matrix and translation are written through csr_we, csr_index
// and csr_wdata; the user must do so only while no transaction is in flight, as
// the block itself does not enforce this. The vector is captured in an input
// register at the accepting edge, the three row datapaths evaluate it in one
// pass, and the result register loads it when empty or when its result leaves,
// raising rsp_valid. Throughput is one transaction per cycle; the block has no
// state carried between vectors, so only the result register's stall limits it.
// When the receiver stalls, the result holds, and the input register still takes
// one more transaction if it is empty; after that req_stall rises.
// Reset is synchronous and active high; it empties both registers and clears the
// configuration to zero.
module rotate_translate_vector_with_flags_core
   import rtv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_wdata
);

   cfg_type       cfg;

   // Input register stage.
   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_data_ff;
   logic          in_load;

   // Result register stage.
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       out_data_ff;
   rsp_type       out_data_in;
   logic          out_advance;

   logic signed [MAC_W-1:0] mac [ROWS];
   logic signed [IR_W-1:0]  ir  [ROWS];
   row_flags_type           row_flags [ROWS];
   logic [FLAGS_W-1:0]      flags_raw;

   rtv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      rtv_row u_row (
         .rot_row   (cfg.rot[r]),
         .trans     (cfg.trans[r]),
         .vec       (in_data_ff),
         .mac       (mac[r]),
         .ir        (ir[r]),
         .row_flags (row_flags[r])
      );
   end

   // The result register may load whenever it is empty or its transaction leaves.
   // The input register may load whenever it is empty or its item moves on.
   assign out_advance  = !out_valid_ff || !rsp_stall;
   assign in_load      = !in_valid_ff || out_advance;
   assign req_stall    = !in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   always_comb begin
      flags_raw = '0;
      for (int r = 0; r < ROWS; r++) begin
         flags_raw[FLAG_POS_TOP - r] = row_flags[r].pos_ovf;
         flags_raw[FLAG_NEG_TOP - r] = row_flags[r].neg_ovf;
         flags_raw[FLAG_SAT_TOP - r] = row_flags[r].sat;
      end
      flags_raw[FLAG_SUMMARY] = |(flags_raw & FLAG_SUMMARY_MASK);
   end

   always_comb begin
      out_data_in.mac_x = mac[0];
      out_data_in.mac_y = mac[1];
      out_data_in.mac_z = mac[2];
      out_data_in.ir_x  = ir[0];
      out_data_in.ir_y  = ir[1];
      out_data_in.ir_z  = ir[2];
      out_data_in.flags = flags_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // An accepted transaction is held in the input register in the next cycle.
   `ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, in_valid_ff,
                "accepted transaction not captured")

   // A transaction waiting behind a stalled result is never dropped.
   `ASSERT_NEXT(a_no_drop, clock, reset, in_valid_ff && rsp_valid && rsp_stall,
                in_valid_ff, "waiting transaction lost under stall")

   // The summary bit matches the masked error bits of every delivered result.
   `ASSERT_CLK(a_summary, clock, reset,
               rsp_valid |-> (rsp_data.flags[FLAG_SUMMARY] ==
                              |(rsp_data.flags & FLAG_SUMMARY_MASK)),
               "flag summary bit inconsistent")

   // Only the defined flag positions may ever be set.
   `ASSERT_CLK(a_flag_unused, clock, reset,
               rsp_valid |-> ((rsp_data.flags & 32'h003F_FFFF) == '0),
               "undefined flag bit set")

endmodule

// File: tb/rtv_transform_checker.sv
// Checker for the rotate-translate block: predicts each result from the accepted vectors and
// the register writes it observes, and compares the results as they leave. Depends on rtv_pkg.
`timescale 1ns / 1ps

module rtv_transform_checker
   import rtv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   outstanding
);

   cfg_type transform_cfg;
   rsp_type awaited_results [$];

   // Rotate and translate one vector with the current matrix and translation.
   function automatic rsp_type transform_vector(input req_type vec);
      logic signed [VEC_W-1:0]  comp [ROWS];
      logic signed [COEF_W-1:0] coef;
      longint                   acc;
      longint                   acc_limit;
      logic [ACC_W-1:0]         wrapped;
      logic [MAC_W-1:0]         mac [ROWS];
      logic [IR_W-1:0]          ir [ROWS];
      logic [FLAGS_W-1:0]       flg;
      rsp_type                  res;
      acc_limit = longint'(1) <<< (ACC_W - 1);
      comp[0] = vec.vec_x;
      comp[1] = vec.vec_y;
      comp[2] = vec.vec_z;
      flg = '0;
      for (int r = 0; r < ROWS; r++) begin
         acc = longint'($signed(transform_cfg.trans[r])) <<< FRAC_W;
         wrapped = acc[ACC_W-1:0];
         for (int c = 0; c < ROWS; c++) begin
            coef = transform_cfg.rot[r][c*COEF_W +: COEF_W];
            acc = acc + longint'(coef) * longint'(comp[c]);
            // Overflow is judged on the unwrapped sum, then the sum wraps to 44 bits.
            if (acc >= acc_limit) flg[FLAG_POS_TOP - r] = 1'b1;
            if (acc < -acc_limit) flg[FLAG_NEG_TOP - r] = 1'b1;
            wrapped = acc[ACC_W-1:0];
            acc = longint'($signed(wrapped));
         end
         mac[r] = wrapped[ACC_W-1:FRAC_W];
         if ($signed(mac[r]) < IR_MIN) begin
            ir[r] = IR_MIN;
            flg[FLAG_SAT_TOP - r] = 1'b1;
         end else if ($signed(mac[r]) > IR_MAX) begin
            ir[r] = IR_MAX;
            flg[FLAG_SAT_TOP - r] = 1'b1;
         end else begin
            ir[r] = mac[r][IR_W-1:0];
         end
      end
      if (|(flg & FLAG_SUMMARY_MASK)) flg[FLAG_SUMMARY] = 1'b1;
      res.mac_x = mac[0];
      res.mac_y = mac[1];
      res.mac_z = mac[2];
      res.ir_x  = ir[0];
      res.ir_y  = ir[1];
      res.ir_z  = ir[2];
      res.flags = flg;
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [FLAGS_W-1:0] want,
                                input logic [FLAGS_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         transform_cfg = '0;
         awaited_results.delete();
         mismatch_count = 0;
         outstanding = 0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_ROT_ROW0: transform_cfg.rot[0]   = csr_wdata;
               CSR_ROT_ROW1: transform_cfg.rot[1]   = csr_wdata;
               CSR_ROT_ROW2: transform_cfg.rot[2]   = csr_wdata;
               CSR_TRANS_X:  transform_cfg.trans[0] = csr_wdata[TRANS_W-1:0];
               CSR_TRANS_Y:  transform_cfg.trans[1] = csr_wdata[TRANS_W-1:0];
               CSR_TRANS_Z:  transform_cfg.trans[2] = csr_wdata[TRANS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) awaited_results.push_back(transform_vector(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result transaction with no vector outstanding: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("mac_x", want.mac_x, rsp_data.mac_x);
               compare_field("mac_y", want.mac_y, rsp_data.mac_y);
               compare_field("mac_z", want.mac_z, rsp_data.mac_z);
               compare_field("ir_x", FLAGS_W'(want.ir_x), FLAGS_W'(rsp_data.ir_x));
               compare_field("ir_y", FLAGS_W'(want.ir_y), FLAGS_W'(rsp_data.ir_y));
               compare_field("ir_z", FLAGS_W'(want.ir_z), FLAGS_W'(rsp_data.ir_z));
               compare_field("flags", want.flags, rsp_data.flags);
            end
         end
         outstanding = awaited_results.size();
      end
   end

endmodule

// File: tb/rotate_translate_vector_with_flags_core_tb.sv
// Testbench top for the rotate-translate block: clock, reset, stimulus and verdict.
// Depends on rtv_pkg, the block itself and rtv_transform_checker.
`timescale 1ns / 1ps

module rotate_translate_vector_with_flags_core_tb;
   import rtv_pkg::*;

   localparam int HALF_PERIOD_NS  = 5;
   localparam int RESET_CYCLES    = 10;
   localparam int LATENCY         = 2;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int TIMEOUT_NS      = 3_000_000;

   // Indexes the block decodes to nothing; writes to them must change no register.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // 1.0 in the 1.3.12 coefficient format, and the 16-bit and 32-bit extremes.
   localparam logic [COEF_W-1:0]  COEF_ONE = 16'h1000;
   localparam logic [COEF_W-1:0]  S16_MAX  = 16'h7FFF;
   localparam logic [COEF_W-1:0]  S16_MIN  = 16'h8000;
   localparam logic [TRANS_W-1:0] S32_MAX  = 32'h7FFF_FFFF;
   localparam logic [TRANS_W-1:0] S32_MIN  = 32'h8000_0000;

   typedef enum int {
      FILL_FULL,
      FILL_MODEST,
      FILL_CORNER
   } fill_style_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0]     csr_wdata;
   int                   mismatch_count;
   int                   outstanding;
   logic                 no_gaps;

   rotate_translate_vector_with_flags_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The checker watches both channels and the register port; it never drives the block.
   rtv_transform_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [COEF_W-1:0] corner16();
      case ($urandom_range(0, 4))
         0: return S16_MIN;
         1: return S16_MAX;
         2: return '1;
         3: return '0;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [TRANS_W-1:0] corner32();
      case ($urandom_range(0, 4))
         0: return S32_MIN;
         1: return S32_MAX;
         2: return '1;
         3: return '0;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic req_type vec3(input logic [VEC_W-1:0] x, y, z);
      req_type vec;
      vec.vec_x = x;
      vec.vec_y = y;
      vec.vec_z = z;
      return vec;
   endfunction

   // A matrix row holds column 0 in its low 16 bits.
   function automatic logic [ROW_W-1:0] row3(input logic [COEF_W-1:0] c0, c1, c2);
      return {c2, c1, c0};
   endfunction

   function automatic logic [COEF_W-1:0] random_coef(input fill_style_type style);
      case (style)
         FILL_FULL:   return COEF_W'($urandom);
         FILL_MODEST: return COEF_W'($urandom_range(0, 8192) - 4096);
         default:     return corner16();
      endcase
   endfunction

   function automatic logic [TRANS_W-1:0] random_trans(input fill_style_type style);
      case (style)
         FILL_FULL:   return $urandom;
         FILL_MODEST: return TRANS_W'($urandom_range(0, 65535) - 32768);
         default:     return corner32();
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] random_row(input fill_style_type style);
      return row3(random_coef(style), random_coef(style), random_coef(style));
   endfunction

   // Half the vectors are fully random, the rest small values or corners, so that rows
   // land both inside the IR range and far outside it.
   function automatic req_type random_vector();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return vec3(random_coef(FILL_FULL), random_coef(FILL_FULL),
                                 random_coef(FILL_FULL));
      if (roll < 80) return vec3(VEC_W'($urandom_range(0, 2048) - 1024),
                                 VEC_W'($urandom_range(0, 2048) - 1024),
                                 VEC_W'($urandom_range(0, 2048) - 1024));
      return vec3(corner16(), corner16(), random_coef(FILL_FULL));
   endfunction

   // Offer one vector after a random idle stretch and hold it until the block takes it.
   // Valid stays high after acceptance so that back-to-back transactions are possible.
   task automatic send_vector(input req_type vec);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= random_vector();
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= vec;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Stop offering vectors, wait for every predicted result to come back, and let the
   // pipeline empty so that nothing is in flight.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [ROW_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Rewrite all six registers while the block is idle. The translation writes carry
   // random junk above bit 31, and every load also hits one of the unused indexes.
   task automatic load_config(input logic [ROW_W-1:0] r0, r1, r2,
                              input logic [TRANS_W-1:0] tx, ty, tz);
      drain();
      write_reg(CSR_ROT_ROW0, r0);
      write_reg(CSR_ROT_ROW1, r1);
      write_reg(CSR_ROT_ROW2, r2);
      write_reg(CSR_TRANS_X, {16'($urandom), tx});
      write_reg(CSR_TRANS_Y, {16'($urandom), ty});
      write_reg(CSR_TRANS_Z, {16'($urandom), tz});
      write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                ROW_W'({$urandom, $urandom}));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // The receiver stalls at random. Now and then it stays ready for a long stretch so
   // that the block also runs at full rate.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end else begin
            hold = pick_gap();
            if (hold > 0) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
               repeat (hold - 1) @(negedge clock);
            end
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

   initial begin
      fill_style_type style;
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_gaps   = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Registers still at their reset value: every row sums to zero.
      send_vector(vec3(S16_MAX, S16_MIN, '1));

      // Unit diagonal without translation: the MAC values reproduce the vector.
      load_config(row3(COEF_ONE, '0, '0), row3('0, COEF_ONE, '0), row3('0, '0, COEF_ONE),
                  '0, '0, '0);
      send_vector(vec3('0, '0, '0));
      send_vector(vec3(S16_MAX, S16_MAX, S16_MAX));
      send_vector(vec3(S16_MIN, S16_MIN, S16_MIN));
      send_vector(vec3(16'h0001, '1, 16'h5555));
      send_vector(vec3(16'hAAAA, 16'h1234, 16'hF000));

      // Largest coefficients and translation: positive overflow on every row, and a
      // sum that overflows on the first add and then wraps back.
      load_config(row3(S16_MAX, S16_MAX, S16_MAX), row3(S16_MAX, S16_MAX, S16_MAX),
                  row3(S16_MAX, S16_MAX, S16_MAX), S32_MAX, S32_MAX, S32_MAX);
      send_vector(vec3(S16_MAX, S16_MAX, S16_MAX));
      send_vector(vec3(S16_MIN, S16_MIN, S16_MIN));
      send_vector(vec3(S16_MAX, S16_MIN, '0));

      // Most negative coefficients and translation: negative overflow, and a sum that
      // sits exactly at the lower bound without raising the flag.
      load_config(row3(S16_MIN, S16_MIN, S16_MIN), row3(S16_MIN, S16_MIN, S16_MIN),
                  row3(S16_MIN, S16_MIN, S16_MIN), S32_MIN, S32_MIN, S32_MIN);
      send_vector(vec3(S16_MAX, S16_MAX, S16_MAX));
      send_vector(vec3(S16_MIN, S16_MIN, S16_MIN));
      send_vector(vec3('0, '0, '0));

      // Only row 2 saturates; its flag lies outside the summary mask, so bit 31 stays low.
      load_config('0, '0, row3(S16_MAX, '0, '0), '0, '0, '0);
      send_vector(vec3(S16_MAX, '0, '0));
      send_vector(vec3(S16_MIN, '0, '0));
      send_vector(vec3('0, S16_MAX, S16_MAX));

      // MAC values right at the edges of the IR range and one step beyond them.
      load_config(row3(COEF_ONE, '0, '0), row3('0, COEF_ONE, '0), row3('0, '0, COEF_ONE),
                  32'sd32767, 32'sd32768, -32'sd32768);
      send_vector(vec3('0, '0, '0));
      send_vector(vec3(16'h0001, '1, '1));

      // Sums that land exactly on the overflow bounds and just past them.
      load_config(row3(COEF_ONE, '0, '0), row3(COEF_ONE, '0, '0), row3('0, '0, S16_MIN),
                  S32_MAX, S32_MIN, S32_MIN);
      send_vector(vec3(16'h0001, '0, '0));
      send_vector(vec3('1, '0, 16'h0001));
      send_vector(vec3('0, '0, '0));

      // Random phases cycle through full-range, moderate and corner-value settings.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = fill_style_type'(phase % 3);
         load_config(random_row(style), random_row(style), random_row(style),
                     random_trans(style), random_trans(style), random_trans(style));
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_PHASE) send_vector(random_vector());
      end

      drain();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/rtv_pkg.sv
design/rtv_csr.sv
design/rtv_row.sv
design/rotate_translate_vector_with_flags_core.sv
tb/rtv_transform_checker.sv
tb/rotate_translate_vector_with_flags_core_tb.sv
